### sv/opln_pkg.sv
// Package for the ordered point list nearest unit: op codes, status codes,
// sizes and the sequencer-to-cell control struct. No dependencies.
package opln_pkg;

	localparam int unsigned MaxEntriesDefault = 16;
	localparam int unsigned ResultCap = 16;
	localparam int unsigned CoordW = 16;
	localparam int unsigned DistW = 34;

	typedef enum logic [3:0] {
		OP_INS_HEAD   = 4'd0,
		OP_INS_TAIL   = 4'd1,
		OP_RM_FIRST   = 4'd2,
		OP_RM_LAST    = 4'd3,
		OP_FIND       = 4'd4,
		OP_INS_AFTER  = 4'd5,
		OP_INS_BEFORE = 4'd6,
		OP_RM_CLOSEST = 4'd7,
		OP_DUMP       = 4'd8,
		OP_DUMP_REV   = 4'd9
	} op_t;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// Per-cycle command from the sequencer to every cell of the chain.
	typedef struct packed {
		logic shift_up;     // cells at index > pos take their lower neighbor
		logic shift_down;   // cells at index >= pos take their upper neighbor
		logic write;        // cell at index pos takes the new point
		logic rotate;       // valid entries rotate one place toward the head
	} cell_ctl_t;

endpackage

### sv/opln_cell.sv
// One storage cell of the ordered point chain: holds one point.
// Depends on opln_pkg for the control struct and widths.
module opln_cell #(
	parameter int unsigned IDX_W = 4
) (
	input  logic                                clk,
	input  opln_pkg::cell_ctl_t                 ctl,
	input  logic [IDX_W-1:0]                    pos,
	input  logic [IDX_W-1:0]                    my_idx,
	input  logic [opln_pkg::CoordW-1:0]         new_re,
	input  logic [opln_pkg::CoordW-1:0]         new_im,
	input  logic [opln_pkg::CoordW-1:0]         lo_re,
	input  logic [opln_pkg::CoordW-1:0]         lo_im,
	input  logic [opln_pkg::CoordW-1:0]         hi_re,
	input  logic [opln_pkg::CoordW-1:0]         hi_im,
	output logic [opln_pkg::CoordW-1:0]         re_q,
	output logic [opln_pkg::CoordW-1:0]         im_q
);

	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			re_q <= hi_re;
			im_q <= hi_im;
		end else if (ctl.write && my_idx == pos) begin
			re_q <= new_re;
			im_q <= new_im;
		end else if (ctl.shift_up && my_idx > pos) begin
			re_q <= lo_re;
			im_q <= lo_im;
		end else if (ctl.shift_down && my_idx >= pos) begin
			re_q <= hi_re;
			im_q <= hi_im;
		end
	end

endmodule

### sv/opln_dist.sv
// Squared distance stage: two registered products, then a registered sum.
// Depends on opln_pkg for widths.
module opln_dist (
	input  logic                              clk,
	input  logic signed [opln_pkg::CoordW-1:0] a_re,
	input  logic signed [opln_pkg::CoordW-1:0] a_im,
	input  logic signed [opln_pkg::CoordW-1:0] q_re,
	input  logic signed [opln_pkg::CoordW-1:0] q_im,
	output logic [opln_pkg::DistW-1:0]        dist_s2
);

	logic signed [opln_pkg::CoordW:0] dr, di;
	logic signed [2*opln_pkg::CoordW+1:0] sq_re, sq_im;
	logic [2*opln_pkg::CoordW+1:0] pr_s1, pi_s1;

	assign dr = {a_re[opln_pkg::CoordW-1], a_re} - {q_re[opln_pkg::CoordW-1], q_re};
	assign di = {a_im[opln_pkg::CoordW-1], a_im} - {q_im[opln_pkg::CoordW-1], q_im};

	// full-width squares of the 17-bit differences
	assign sq_re = dr * dr;
	assign sq_im = di * di;

	always_ff @(posedge clk) begin
		pr_s1 <= $unsigned(sq_re);
		pi_s1 <= $unsigned(sq_im);
		dist_s2 <= opln_pkg::DistW'(pr_s1) + opln_pkg::DistW'(pi_s1);
	end

endmodule

### sv/ordered_point_list_nearest_unit.sv
// Ordered point list with nearest-point search, built as a chain of cells.
// Head/tail inserts and removes go straight to the edit state, full/empty
// answers to the output state; searches rotate the chain past a two-stage
// distance pipeline; forward dumps give one result per cycle, reverse dumps
// rotate the chain a full turn first, then read it by index from the tail.
// One request at a time, busy high meanwhile; reset clears the count; no stall.
module ordered_point_list_nearest_unit #(
	parameter int unsigned MAX_ENTRIES = opln_pkg::MaxEntriesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  op,
	input  logic signed [15:0] real_part,
	input  logic signed [15:0] imag_part,
	output logic        strobe,
	output logic [1:0]  status,
	output logic signed [15:0] out_real,
	output logic signed [15:0] out_imag,
	output logic [3:0]  position,
	output logic        last_of_run
);

	localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned CW = opln_pkg::CoordW;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_EDIT, S_DUMP, S_OUT
	} state_t;

	state_t state_q;
	opln_pkg::cell_ctl_t ctl;
	logic [IDX_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] step_q;
	logic [3:0] op_q;
	logic [CW-1:0] q_re_q, q_im_q;
	logic [CW-1:0] cre [MAX_ENTRIES];
	logic [CW-1:0] cim [MAX_ENTRIES];
	logic [opln_pkg::DistW-1:0] dist_s2, best_d_q;
	logic [IDX_W-1:0] best_q;
	logic [CNT_W-1:0] seen_q;   // distances consumed
	logic [CNT_W-1:0] rot_q;    // rotations issued
	logic [4:0] emit_q;

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		logic [CW-1:0] lre, lim, hre, him;
		if (g == 0) begin : g_lo
			assign lre = cre[0];
			assign lim = cim[0];
		end else begin : g_lo
			assign lre = cre[g-1];
			assign lim = cim[g-1];
		end
		// rotation wraps through the last valid entry: the head feeds in at the top
		// of the valid region, so the chain index rotates within cnt entries
		assign hre = (g + 1 >= MAX_ENTRIES || CNT_W'(g + 1) >= cnt_q) ?
			cre[0] : cre[(g + 1 < MAX_ENTRIES) ? g + 1 : 0];
		assign him = (g + 1 >= MAX_ENTRIES || CNT_W'(g + 1) >= cnt_q) ?
			cim[0] : cim[(g + 1 < MAX_ENTRIES) ? g + 1 : 0];
		opln_cell #(.IDX_W(IDX_W)) u_cell (
			.clk(clk), .ctl(ctl), .pos(pos_q), .my_idx(IDX_W'(g)),
			.new_re(q_re_q), .new_im(q_im_q),
			.lo_re(lre), .lo_im(lim), .hi_re(hre), .hi_im(him),
			.re_q(cre[g]), .im_q(cim[g])
		);
	end

	// head of chain feeds the distance pipeline while rotating
	opln_dist u_dist (
		.clk(clk), .a_re(cre[0]), .a_im(cim[0]), .q_re(q_re_q), .q_im(q_im_q),
		.dist_s2(dist_s2)
	);

	logic is_ins;
	assign is_ins = (op_q == opln_pkg::OP_INS_AFTER) || (op_q == opln_pkg::OP_INS_BEFORE);

	always_comb begin
		ctl = '0;
		if (state_q == S_SCAN && rot_q < cnt_q) ctl.rotate = 1'b1;
		if (state_q == S_DUMP && rot_q < cnt_q) ctl.rotate = 1'b1;
		// finish the rotation of a truncated forward dump
		if (state_q == S_OUT && op_q == opln_pkg::OP_FIND && seen_q != '0) ctl.rotate = 1'b1;
		if (state_q == S_EDIT) begin
			if (op_q == opln_pkg::OP_INS_HEAD || op_q == opln_pkg::OP_INS_TAIL || is_ins) begin
				ctl.shift_up = 1'b1;
				ctl.write = 1'b1;
			end else if (op_q != opln_pkg::OP_FIND) begin
				ctl.shift_down = 1'b1;
			end
		end
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			strobe <= 1'b0;
			last_of_run <= 1'b0;
			rot_q <= '0;
			seen_q <= '0;
			emit_q <= '0;
		end else begin
			strobe <= 1'b0;
			last_of_run <= 1'b0;
			case (state_q)
			S_IDLE: begin
				if (start && op <= opln_pkg::OP_DUMP_REV) begin
					op_q <= op;
					q_re_q <= real_part;
					q_im_q <= imag_part;
					rot_q <= '0;
					seen_q <= '0;
					emit_q <= '0;
					step_q <= '0;
					status <= opln_pkg::STAT_OK;
					out_real <= '0;
					out_imag <= '0;
					position <= '0;
					if ((op == opln_pkg::OP_INS_HEAD || op == opln_pkg::OP_INS_TAIL ||
					     op == opln_pkg::OP_INS_AFTER || op == opln_pkg::OP_INS_BEFORE) &&
					    cnt_q >= CNT_W'(MAX_ENTRIES)) begin
						status <= opln_pkg::STAT_FULL;
						out_real <= real_part;
						out_imag <= imag_part;
						state_q <= S_OUT;
					end else if (cnt_q == '0 && !(op == opln_pkg::OP_INS_HEAD ||
					     op == opln_pkg::OP_INS_TAIL || op == opln_pkg::OP_INS_AFTER ||
					     op == opln_pkg::OP_INS_BEFORE)) begin
						status <= opln_pkg::STAT_EMPTY;
						state_q <= S_OUT;
					end else if (op == opln_pkg::OP_INS_HEAD || op == opln_pkg::OP_RM_FIRST ||
					     (cnt_q == '0)) begin
						pos_q <= '0;
						state_q <= S_EDIT;
					end else if (op == opln_pkg::OP_INS_TAIL) begin
						pos_q <= IDX_W'(cnt_q);
						state_q <= S_EDIT;
					end else if (op == opln_pkg::OP_RM_LAST) begin
						pos_q <= IDX_W'(cnt_q - 1'b1);
						state_q <= S_EDIT;
					end else if (op == opln_pkg::OP_DUMP || op == opln_pkg::OP_DUMP_REV) begin
						state_q <= S_DUMP;
					end else begin
						state_q <= S_SCAN;
					end
				end
			end
			S_SCAN: begin
				// rotate cnt times; distances arrive behind the head via the product and sum registers
				if (rot_q < cnt_q) rot_q <= rot_q + 1'b1;
				if (step_q != 2'd2) step_q <= step_q + 1'b1;
				if (step_q == 2'd2) begin
					if (seen_q < cnt_q) begin
						seen_q <= seen_q + 1'b1;
						if (seen_q == '0 || dist_s2 < best_d_q) begin
							best_d_q <= dist_s2;
							best_q <= IDX_W'(seen_q);
						end
					end else begin
						if (is_ins) begin
							pos_q <= (op_q == opln_pkg::OP_INS_AFTER) ? best_q + 1'b1 : best_q;
						end else begin
							pos_q <= best_q;
						end
						state_q <= S_EDIT;
					end
				end
			end
			S_EDIT: begin
				strobe <= 1'b1;
				last_of_run <= 1'b1;
				status <= opln_pkg::STAT_OK;
				position <= 4'(pos_q);
				if (op_q == opln_pkg::OP_INS_HEAD || op_q == opln_pkg::OP_INS_TAIL || is_ins) begin
					out_real <= q_re_q;
					out_imag <= q_im_q;
					cnt_q <= cnt_q + 1'b1;
				end else begin
					out_real <= cre[pos_q];
					out_imag <= cim[pos_q];
					if (op_q != opln_pkg::OP_FIND) cnt_q <= cnt_q - 1'b1;
				end
				state_q <= S_IDLE;
			end
			S_DUMP: begin
				// forward: emit head then rotate; reverse: rotate a full turn, then read from the tail
				if (op_q == opln_pkg::OP_DUMP) begin
					strobe <= 1'b1;
					status <= opln_pkg::STAT_OK;
					out_real <= cre[0];
					out_imag <= cim[0];
					position <= 4'(rot_q);
					rot_q <= rot_q + 1'b1;
					emit_q <= emit_q + 1'b1;
					if (rot_q + 1'b1 == cnt_q || emit_q == 5'(opln_pkg::ResultCap - 1)) begin
						last_of_run <= 1'b1;
						state_q <= (rot_q + 1'b1 == cnt_q) ? S_IDLE : S_OUT;
						if (rot_q + 1'b1 != cnt_q) begin
							seen_q <= cnt_q - rot_q - 1'b1;
							op_q <= opln_pkg::OP_FIND;
						end
					end
				end else begin
					if (rot_q + 1'b1 == cnt_q) begin
						op_q <= opln_pkg::OP_RM_LAST;
						state_q <= S_OUT;
						rot_q <= '0;
					end else begin
						rot_q <= rot_q + 1'b1;
					end
				end
			end
			default: begin // S_OUT
				if (op_q == opln_pkg::OP_FIND && seen_q != '0) begin
					// finish realigning a truncated forward dump
					seen_q <= seen_q - 1'b1;
					if (seen_q == CNT_W'(1)) state_q <= S_IDLE;
				end else if (op_q == opln_pkg::OP_RM_LAST && cnt_q != '0 &&
				     status == opln_pkg::STAT_OK) begin
					// reverse dump: walk chain by index from tail
					strobe <= 1'b1;
					out_real <= cre[IDX_W'(cnt_q - 1'b1 - rot_q)];
					out_imag <= cim[IDX_W'(cnt_q - 1'b1 - rot_q)];
					position <= 4'(cnt_q - 1'b1 - rot_q);
					rot_q <= rot_q + 1'b1;
					emit_q <= emit_q + 1'b1;
					if (rot_q + 1'b1 == cnt_q || emit_q == 5'(opln_pkg::ResultCap - 1)) begin
						last_of_run <= 1'b1;
						state_q <= S_IDLE;
					end
				end else begin
					strobe <= 1'b1;
					last_of_run <= 1'b1;
					state_q <= S_IDLE;
				end
			end
			endcase
		end
	end

endmodule

### tb/sv/tb.sv
// Testbench for ordered_point_list_nearest_unit: drives point-list requests from a queue,
// predicts every result with its own list model and checks each strobed result.
// Depends on opln_pkg and the unit RTL.
module tb;

	localparam int unsigned Depth = 16;
	localparam int unsigned IdleLimit = 20000;

	typedef struct packed {
		logic [3:0]  op;
		logic [15:0] re;
		logic [15:0] im;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] re;
		logic [15:0] im;
		logic [3:0]  pos;
		logic        last;
	} point_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [3:0] op = 4'd0;
	logic signed [15:0] real_part = '0;
	logic signed [15:0] imag_part = '0;
	logic strobe;
	logic [1:0] status;
	logic signed [15:0] out_real;
	logic signed [15:0] out_imag;
	logic [3:0] position;
	logic last_of_run;

	request_t pending_requests[$];
	point_result_t expected_points[$];
	logic [15:0] list_re[Depth];
	logic [15:0] list_im[Depth];
	int unsigned list_len = 0;
	int unsigned error_count = 0;
	int unsigned accepted_count = 0;
	int unsigned result_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned gap_left = 0;
	bit driving_done = 1'b0;

	ordered_point_list_nearest_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.real_part(real_part), .imag_part(imag_part), .strobe(strobe),
		.status(status), .out_real(out_real), .out_imag(out_imag),
		.position(position), .last_of_run(last_of_run)
	);

	always #5 clk = ~clk;

	task automatic report(input string what);
		error_count++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	function automatic int unsigned nearest_index(input logic [15:0] qr, input logic [15:0] qi);
		int unsigned best;
		longint best_d;
		longint dr;
		longint di;
		longint d;
		best = 0;
		best_d = 0;
		for (int unsigned i = 0; i < list_len; i++) begin
			dr = longint'($signed(list_re[i])) - longint'($signed(qr));
			di = longint'($signed(list_im[i])) - longint'($signed(qi));
			d = dr * dr + di * di;
			if (i == 0 || d < best_d) begin
				best_d = d;
				best = i;
			end
		end
		return best;
	endfunction

	function automatic point_result_t mk(input logic [1:0] s, input logic [15:0] r,
			input logic [15:0] i, input int unsigned p, input logic l);
		point_result_t x;
		x.status = s;
		x.re = r;
		x.im = i;
		x.pos = p[3:0];
		x.last = l;
		return x;
	endfunction

	// Update the list copy and queue the results one request causes.
	task automatic predict_points(input request_t rq);
		int unsigned p;
		opln_pkg::op_t code;
		if (rq.op > opln_pkg::OP_DUMP_REV) return;
		code = opln_pkg::op_t'(rq.op);
		case (code)
			opln_pkg::OP_INS_HEAD, opln_pkg::OP_INS_TAIL, opln_pkg::OP_INS_AFTER,
			opln_pkg::OP_INS_BEFORE: begin
				if (list_len >= Depth) begin
					expected_points.push_back(mk(opln_pkg::STAT_FULL, rq.re, rq.im, 0, 1'b1));
				end else begin
					if (code == opln_pkg::OP_INS_HEAD || list_len == 0) p = 0;
					else if (code == opln_pkg::OP_INS_TAIL) p = list_len;
					else p = nearest_index(rq.re, rq.im) +
						(code == opln_pkg::OP_INS_AFTER ? 1 : 0);
					for (int unsigned i = list_len; i > p; i--) begin
						list_re[i] = list_re[i - 1];
						list_im[i] = list_im[i - 1];
					end
					list_re[p] = rq.re;
					list_im[p] = rq.im;
					list_len++;
					expected_points.push_back(mk(opln_pkg::STAT_OK, rq.re, rq.im, p, 1'b1));
				end
			end
			opln_pkg::OP_DUMP, opln_pkg::OP_DUMP_REV: begin
				if (list_len == 0)
					expected_points.push_back(mk(opln_pkg::STAT_EMPTY, 0, 0, 0, 1'b1));
				for (int unsigned i = 0; i < list_len; i++) begin
					p = (code == opln_pkg::OP_DUMP) ? i : list_len - 1 - i;
					expected_points.push_back(mk(opln_pkg::STAT_OK, list_re[p], list_im[p], p,
						i == list_len - 1));
				end
			end
			default: begin
				if (list_len == 0) begin
					expected_points.push_back(mk(opln_pkg::STAT_EMPTY, 0, 0, 0, 1'b1));
				end else begin
					if (code == opln_pkg::OP_RM_FIRST) p = 0;
					else if (code == opln_pkg::OP_RM_LAST) p = list_len - 1;
					else p = nearest_index(rq.re, rq.im);
					expected_points.push_back(mk(opln_pkg::STAT_OK, list_re[p], list_im[p], p,
						1'b1));
					if (code != opln_pkg::OP_FIND) begin
						for (int unsigned i = p; i + 1 < list_len; i++) begin
							list_re[i] = list_re[i + 1];
							list_im[i] = list_im[i + 1];
						end
						list_len--;
					end
				end
			end
		endcase
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($signed($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add(input logic [3:0] o, input logic [15:0] r, input logic [15:0] i);
		request_t rq;
		rq.op = o;
		rq.re = r;
		rq.im = i;
		pending_requests.push_back(rq);
	endtask

	// Driver: hold start until the request is taken, then idle a random gap.
	always @(posedge clk) begin
		if (start && !busy) begin
			accepted_count++;
			predict_points(request_t'{op, real_part, imag_part});
			gap_left <= pick_gap();
		end
		if (start && busy) begin
			// hold current request
		end else if (gap_left != 0 && !(start && !busy)) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (gap_left == 0 && !(start && !busy) && pending_requests.size() != 0
				&& arst_n) begin
			request_t rq;
			rq = pending_requests.pop_front();
			op <= rq.op;
			real_part <= rq.re;
			imag_part <= rq.im;
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: compare each strobed result with the oldest expectation.
	always @(posedge clk) begin
		point_result_t exp_pt;
		if (strobe) begin
			result_count++;
			if (expected_points.size() == 0) begin
				report($sformatf("unexpected result status=%0d pos=%0d", status, position));
			end else begin
				exp_pt = expected_points.pop_front();
				if (status !== exp_pt.status)
					report($sformatf("status %0d, want %0d", status, exp_pt.status));
				if (out_real !== exp_pt.re)
					report($sformatf("out_real %h, want %h", out_real, exp_pt.re));
				if (out_imag !== exp_pt.im)
					report($sformatf("out_imag %h, want %h", out_imag, exp_pt.im));
				if (position !== exp_pt.pos)
					report($sformatf("position %0d, want %0d", position, exp_pt.pos));
				if (last_of_run !== exp_pt.last)
					report($sformatf("last_of_run %b, want %b", last_of_run, exp_pt.last));
			end
		end
	end

	// Watchdog: count cycles with no request or result taken.
	always @(posedge clk) begin
		if ((start && !busy) || strobe) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Timeout: no progress for %0d cycles", IdleLimit);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		// directed: empty cases, fill to full, extremes, every op
		add(opln_pkg::OP_RM_FIRST, 0, 0);
		add(opln_pkg::OP_RM_LAST, 0, 0);
		add(opln_pkg::OP_FIND, 16'h1234, 0);
		add(opln_pkg::OP_RM_CLOSEST, 0, 0);
		add(opln_pkg::OP_DUMP, 0, 0);
		add(opln_pkg::OP_DUMP_REV, 0, 0);
		add(opln_pkg::OP_INS_AFTER, 16'h7FFF, 16'h8000);
		add(opln_pkg::OP_INS_BEFORE, 16'h8000, 16'h7FFF);
		add(4'd10, 0, 0);
		add(4'd15, 16'hFFFF, 16'hFFFF);
		add(opln_pkg::OP_INS_HEAD, 16'hFFFF, 16'h0000);
		add(opln_pkg::OP_INS_TAIL, 16'h0100, 16'h0100);
		add(opln_pkg::OP_INS_AFTER, 16'h0100, 16'h0100);
		add(opln_pkg::OP_INS_BEFORE, 16'h0000, 16'h0000);
		add(opln_pkg::OP_FIND, 16'h8000, 16'h8000);
		for (int i = 0; i < 11; i++) add(opln_pkg::OP_INS_TAIL, 16'(i * 3), 16'(-i));
		add(opln_pkg::OP_INS_HEAD, 16'h5555, 16'hAAAA);
		add(opln_pkg::OP_INS_AFTER, 0, 0);
		add(opln_pkg::OP_DUMP, 0, 0);
		add(opln_pkg::OP_DUMP_REV, 0, 0);
		add(opln_pkg::OP_RM_CLOSEST, 16'h7FFF, 16'h7FFF);
		add(opln_pkg::OP_RM_LAST, 0, 0);
		// random: insert-heavy and remove-heavy phases alternate, so the list sweeps between empty and full
		for (int i = 0; i < 128; i++) begin
			n = $urandom_range(0, 99);
			if (n < 4) add(4'($urandom_range(10, 15)), 16'($urandom), 16'($urandom));
			else if (((i / 40) % 2 == 0) ? n < 65 : n < 25)
				add(4'($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(5, 6)),
					pick_coord(), pick_coord());
			else if (n < 85)
				add(4'($urandom_range(0, 1) ? $urandom_range(2, 4) : 7), pick_coord(), pick_coord());
			else add(4'($urandom_range(8, 9)), pick_coord(), pick_coord());
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_requests.size() == 0 && !start);
		wait (expected_points.size() == 0);
		repeat (60) @(posedge clk);
		$display("Accepted %0d requests and checked %0d results across empty, partly",
			accepted_count, result_count);
		$display("filled and full lists, including dumps and ignored op codes.");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

### ordered_point_list_nearest_unit.f
sv/opln_pkg.sv
sv/opln_cell.sv
sv/opln_dist.sv
sv/ordered_point_list_nearest_unit.sv
tb/sv/tb.sv
